// ----- sv/rgb_histogram_equalizer_unit_macros.svh -----
// Assertion macros shared by the histogram equalizer RTL.
`ifndef RGB_HISTOGRAM_EQUALIZER_UNIT_MACROS_SVH
`define RGB_HISTOGRAM_EQUALIZER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RHE_ASSERT_IMPLY(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("implication check failed");
`define RHE_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RHE_ASSERT_IMPLY(lbl, ant, cons)
`define RHE_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ----- sv/rhe_pkg.sv -----
// Types and constants of the RGB histogram equalizer.
`default_nettype none
package rhe_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ACCUM    = 2'd1,
        OP_FINALIZE = 2'd2,
        OP_MAP      = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_ACC_RD,
        S_ACC_WR,
        S_FIN_RD,
        S_FIN_WR,
        S_FIN_DONE,
        S_MAP_RD,
        S_MAP_MUL,
        S_DIV,
        S_MAP_OUT
    } state_t;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Register index decoded from paddr[2].
    localparam logic REG_MAX_LEVEL = 1'b0;

    localparam logic [7:0] MAX_LEVEL_RESET = 8'd255;

    // Saturate one pixel component to the level limit.
    function automatic logic [7:0] clip_level(input logic [7:0] v, input logic [7:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage
`default_nettype wire

// ----- sv/rgb_histogram_equalizer_unit.sv -----
// Per-channel RGB histogram equalizer: bin memories, prefix-sum sweep and mapping divider.
// An item is taken whenever the sequencer is idle; a result still waiting on the output
// holds only the step that produces the next result. Clear is one write pass that zeroes
// every bin; accumulate reads, then writes back the incremented bins, unless the pixel
// count is saturated; finalize does one read and one write-back per bin, then loads the
// done result; map reads the bins, scales them and runs the bit-serial divider that forms
// the rounded quotient one bit per cycle. After reset the same clearing pass runs before
// the first item is taken.
`default_nettype none
`include "rgb_histogram_equalizer_unit_macros.svh"
module rgb_histogram_equalizer_unit #(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out, green_out, blue_out
    output logic [1:0]  m_tuser,   // result_kind, count_saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rhe_pkg::*;

    localparam int IDXW = $clog2(LEVELS);
    localparam int BW   = COUNT_BITS + 1;
    localparam int DW   = BW + 10;
    localparam int CW   = $clog2(DW);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
    localparam logic [IDXW-1:0]       LAST_IDX  = IDXW'(LEVELS - 1);
    localparam logic [CW-1:0]         LAST_STEP = CW'(DW - 1);
    localparam logic [7:0]            TOP_LEVEL = 8'(LEVELS - 1);

    state_t state_reg, state_next;
    logic [7:0]            max_level_reg;
    logic [7:0]            pix_reg [3];
    logic [COUNT_BITS-1:0] total_reg;
    logic                  sat_reg;
    logic [IDXW-1:0]       fin_idx_reg;
    logic [CW-1:0]         div_cnt_reg;
    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic                  out_sat_reg;
    logic [7:0]            out_pix_reg [3];
    logic [7:0]            mapped [3];
    logic [7:0]            lim;
    logic                  accept;
    logic                  clear_all;
    logic                  fin_start;
    logic                  out_free;
    logic                  load_done;
    logic                  load_map;
    logic                  out_load;
    op_t                   in_op;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LEVEL) ? {24'd0, max_level_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= MAX_LEVEL_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEVEL)
        begin
            max_level_reg <= pwdata[7:0];
        end
    end

    // Input handshake and decoded strobes.
    assign lim       = (max_level_reg > TOP_LEVEL) ? TOP_LEVEL : max_level_reg;
    assign in_op     = op_t'(s_tuser);
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign clear_all = accept && in_op == OP_CLEAR;
    assign fin_start = accept && in_op == OP_FINALIZE;

    // The output register can take a new result when empty or being read.
    assign out_free  = !out_valid_reg || m_tready;
    assign load_done = (state_reg == S_FIN_DONE) && out_free;
    assign load_map  = (state_reg == S_MAP_OUT) && out_free;
    assign out_load  = load_done || load_map;

    // State register; reset starts with the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_CLEAR:    state_next = S_CLR;
                        OP_ACCUM:    state_next = (total_reg == CNT_MAX) ? S_IDLE : S_ACC_RD;
                        OP_FINALIZE: state_next = S_FIN_RD;
                        OP_MAP:      state_next = S_MAP_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_CLR:      state_next = (fin_idx_reg == LAST_IDX) ? S_IDLE : S_CLR;
            S_ACC_RD:   state_next = S_ACC_WR;
            S_ACC_WR:   state_next = S_IDLE;
            S_FIN_RD:   state_next = S_FIN_WR;
            S_FIN_WR:   state_next = (fin_idx_reg == LAST_IDX) ? S_FIN_DONE : S_FIN_RD;
            S_FIN_DONE: state_next = out_free ? S_IDLE : S_FIN_DONE;
            S_MAP_RD:   state_next = S_MAP_MUL;
            S_MAP_MUL:  state_next = S_DIV;
            S_DIV:      state_next = (div_cnt_reg == LAST_STEP) ? S_MAP_OUT : S_DIV;
            S_MAP_OUT:  state_next = out_free ? S_IDLE : S_MAP_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // Pixel capture, pixel count, saturation flag and sweep counters.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg[0] <= clip_level(s_tdata[7:0], lim);
            pix_reg[1] <= clip_level(s_tdata[15:8], lim);
            pix_reg[2] <= clip_level(s_tdata[23:16], lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            sat_reg     <= 1'b0;
            fin_idx_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (clear_all)
            begin
                total_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else if (accept && in_op == OP_ACCUM && total_reg == CNT_MAX)
            begin
                sat_reg <= 1'b1;
            end
            else if (state_reg == S_ACC_WR)
            begin
                total_reg <= total_reg + 1'b1;
            end

            // Bin index shared by the clearing pass and the finalize sweep.
            if (fin_start || clear_all)
            begin
                fin_idx_reg <= '0;
            end
            else if (state_reg == S_FIN_WR || state_reg == S_CLR)
            begin
                fin_idx_reg <= fin_idx_reg + 1'b1;
            end

            if (state_reg == S_MAP_MUL)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // One bin memory, prefix-sum lane and divider per color channel.
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [BW-1:0]         bins_mem [LEVELS];
        logic [BW-1:0]         rd_data_reg;
        logic [IDXW-1:0]       addr;
        logic                  wr_en;
        logic [BW-1:0]         wr_data;
        logic [BW-1:0]         cdf;
        logic [COUNT_BITS-1:0] run_reg;
        logic                  found_reg;
        logic [COUNT_BITS-1:0] cmin_reg;
        logic [BW:0]           fin_sum;
        logic [COUNT_BITS-1:0] fin_sat;
        logic [BW-1:0]         diff;
        logic [BW+7:0]         num;
        logic [COUNT_BITS-1:0] den;
        logic [DW-1:0]         dq_reg;
        logic [COUNT_BITS:0]   rem_reg;
        logic [COUNT_BITS:0]   vdiv_reg;
        logic                  pass_reg;
        logic                  below_reg;
        logic [COUNT_BITS+1:0] trial;
        logic [COUNT_BITS+1:0] trial_sub;
        logic                  ge;

        assign addr    = (state_reg == S_CLR || state_reg == S_FIN_RD || state_reg == S_FIN_WR)
                         ? fin_idx_reg : pix_reg[c][IDXW-1:0];
        assign cdf     = rd_data_reg;
        assign wr_en   = (state_reg == S_ACC_WR) || (state_reg == S_FIN_WR)
                         || (state_reg == S_CLR);
        assign fin_sum = (BW+1)'(run_reg) + (BW+1)'(cdf);
        assign fin_sat = (fin_sum > (BW+1)'(CNT_MAX)) ? CNT_MAX : fin_sum[COUNT_BITS-1:0];
        assign wr_data = (state_reg == S_CLR) ? '0
                         : (state_reg == S_ACC_WR) ? cdf + 1'b1 : BW'(fin_sat);

        // Bin memory: one read and one write port, registered read data.
        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                bins_mem[addr] <= wr_data;
            end
            rd_data_reg <= bins_mem[addr];
        end

        // Running sum and first nonzero cumulative value.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                run_reg   <= '0;
                found_reg <= 1'b0;
                cmin_reg  <= '0;
            end
            else if (clear_all || fin_start)
            begin
                run_reg   <= '0;
                found_reg <= 1'b0;
                cmin_reg  <= '0;
            end
            else if (state_reg == S_FIN_WR)
            begin
                run_reg <= fin_sat;
                if (!found_reg && fin_sat != '0)
                begin
                    cmin_reg  <= fin_sat;
                    found_reg <= 1'b1;
                end
            end
        end

        // Mapping: scaled numerator, then restoring division for round-half-up.
        assign diff      = cdf - BW'(cmin_reg);
        assign num       = (BW+8)'(diff) * (BW+8)'(max_level_reg);
        assign den       = total_reg - cmin_reg;
        assign trial     = {rem_reg, dq_reg[DW-1]};
        assign trial_sub = trial - {1'b0, vdiv_reg};
        assign ge        = trial >= {1'b0, vdiv_reg};

        always_ff @(posedge clk)
        begin
            if (state_reg == S_MAP_MUL)
            begin
                pass_reg  <= total_reg <= cmin_reg;
                below_reg <= cdf <= BW'(cmin_reg);
                dq_reg    <= DW'({num, 1'b0}) + DW'(den);
                vdiv_reg  <= {den, 1'b0};
                rem_reg   <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                rem_reg <= ge ? trial_sub[COUNT_BITS:0] : trial[COUNT_BITS:0];
                dq_reg  <= {dq_reg[DW-2:0], ge};
            end
        end

        always_comb
        begin
            priority if (pass_reg)
                mapped[c] = pix_reg[c];
            else if (below_reg)
                mapped[c] = 8'd0;
            else if (dq_reg > DW'(max_level_reg))
                mapped[c] = max_level_reg;
            else
                mapped[c] = dq_reg[7:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_done)
        begin
            out_kind_reg   <= KIND_DONE;
            out_sat_reg    <= sat_reg;
            out_pix_reg[0] <= 8'd0;
            out_pix_reg[1] <= 8'd0;
            out_pix_reg[2] <= 8'd0;
        end
        else if (load_map)
        begin
            out_kind_reg   <= KIND_PIXEL;
            out_sat_reg    <= sat_reg;
            out_pix_reg[0] <= mapped[0];
            out_pix_reg[1] <= mapped[1];
            out_pix_reg[2] <= mapped[2];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg[2], out_pix_reg[1], out_pix_reg[0]};
    assign m_tuser  = {out_sat_reg, out_kind_reg};

    // Checks on the sequencer.
    `RHE_ASSERT_IMPLY(a_ready_only_idle, s_tready, state_reg == S_IDLE)
    `RHE_ASSERT_NEXT(a_acc_writes_back, state_reg == S_ACC_RD, state_reg == S_ACC_WR)
    `RHE_ASSERT_NEXT(a_result_loads, out_load, m_tvalid)
    `RHE_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RHE_ASSERT_IMPLY(a_total_capped, state_reg == S_ACC_WR, total_reg != CNT_MAX)

endmodule
`default_nettype wire

// ----- tb/rgb_histogram_equalizer_unit_tb.sv -----
// Self-checking testbench for the RGB histogram equalizer unit.
`timescale 1ns / 1ps
`default_nettype none
module rgb_histogram_equalizer_unit_tb;
    import rhe_pkg::*;

    localparam int NUM_LEVELS = 256;
    localparam longint unsigned COUNT_MAX = (64'd1 << 22) - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       saturated;
    } eq_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // red_in, green_in, blue_in
    logic [1:0]  s_tuser;    // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // red_out, green_out, blue_out
    logic [1:0]  m_tuser;    // result_kind, count_saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted block state.
    longint unsigned hist_bins [3][NUM_LEVELS];
    longint unsigned cdf_floor [3];
    longint unsigned pixel_count;
    logic            count_full;
    logic [7:0]      scale_level;

    eq_result_t pending_results[$];
    int         error_count;
    int         cycle_count;
    int         idle_pct;
    int         hold_request;
    int         hold_left;

    rgb_histogram_equalizer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rgb_histogram_equalizer_unit test failed");
            $finish;
        end
    end

    // Receiver readiness: random stalls, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        eq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.kind)
                    report_mismatch("result_kind", m_tuser[0], want.kind);
                if (m_tdata[7:0] !== want.red)
                    report_mismatch("red_out", m_tdata[7:0], want.red);
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("green_out", m_tdata[15:8], want.green);
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch("blue_out", m_tdata[23:16], want.blue);
                if (m_tuser[1] !== want.saturated)
                    report_mismatch("count_saturated", m_tuser[1], want.saturated);
            end
        end
    end

    function automatic void clear_histograms();
        for (int c = 0; c < 3; c++)
        begin
            cdf_floor[c] = 0;
            for (int i = 0; i < NUM_LEVELS; i++)
                hist_bins[c][i] = 0;
        end
        pixel_count = 0;
        count_full = 1'b0;
    endfunction

    // In-place cumulative sum of one channel; returns the first nonzero value.
    function automatic longint unsigned accumulate_cdf(input int c);
        longint unsigned run_sum;
        longint unsigned first;
        bit found;
        run_sum = 0;
        first = 0;
        found = 0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            run_sum += hist_bins[c][i];
            if (run_sum > COUNT_MAX)
                run_sum = COUNT_MAX;
            hist_bins[c][i] = run_sum;
            if (!found && run_sum != 0)
            begin
                first = run_sum;
                found = 1;
            end
        end
        return first;
    endfunction

    function automatic logic [7:0] equalized_level(input int c, input logic [7:0] v);
        longint unsigned scale;
        longint unsigned cdf;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        scale = scale_level;
        cdf = hist_bins[c][v];
        if (pixel_count <= cdf_floor[c])
            return v;
        if (cdf <= cdf_floor[c])
            return 8'd0;
        num = (cdf - cdf_floor[c]) * scale;
        den = pixel_count - cdf_floor[c];
        q = (2 * num + den) / (2 * den);
        return (q > scale) ? scale[7:0] : q[7:0];
    endfunction

    // Update the predicted state for one accepted beat and queue its result.
    function automatic void predict_equalizer(input op_t op, input logic [23:0] pix);
        logic [7:0] lvl [3];
        eq_result_t res;
        for (int c = 0; c < 3; c++)
        begin
            lvl[c] = pix[8*c +: 8];
            if (lvl[c] > scale_level)
                lvl[c] = scale_level;
        end
        case (op)
            OP_CLEAR:
                clear_histograms();
            OP_ACCUM:
                if (pixel_count >= COUNT_MAX)
                    count_full = 1'b1;
                else
                begin
                    pixel_count++;
                    for (int c = 0; c < 3; c++)
                        hist_bins[c][lvl[c]]++;
                end
            OP_FINALIZE:
            begin
                for (int c = 0; c < 3; c++)
                    cdf_floor[c] = accumulate_cdf(c);
                res.kind = KIND_DONE;
                res.red = 8'd0;
                res.green = 8'd0;
                res.blue = 8'd0;
                res.saturated = count_full;
                pending_results.push_back(res);
            end
            default:
            begin
                res.kind = KIND_PIXEL;
                res.red = equalized_level(0, lvl[0]);
                res.green = equalized_level(1, lvl[1]);
                res.blue = equalized_level(2, lvl[2]);
                res.saturated = count_full;
                pending_results.push_back(res);
            end
        endcase
    endfunction

    // Offer one beat after a random gap and wait for the handshake.
    task automatic send_beat(input op_t op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {b, g, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_equalizer(op, {b, g, r});
    endtask

    task automatic send_random_pixel(input op_t op);
        send_beat(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    // Stop offering beats and wait until every predicted result has arrived
    // and the block has gone idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || !s_tready)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Two-phase register write; only called while the block is idle.
    task automatic write_max_level(input logic [7:0] value);
        drain_results();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_MAX_LEVEL, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        scale_level = value;
    endtask

    // One well-formed frame: clear, accumulate, finalize, then map pixels.
    task automatic run_frame(input int n_acc, input int n_map, input int span);
        int base;
        base = $urandom_range(255 - span);
        send_beat(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (n_acc)
            send_beat(OP_ACCUM, 8'(base + $urandom_range(span)),
                      8'(base + $urandom_range(span)), 8'(base + $urandom_range(span)));
        send_random_pixel(OP_FINALIZE);
        repeat (n_map)
            if ($urandom_range(1))
                send_beat(OP_MAP, 8'(base + $urandom_range(span)),
                          8'(base + $urandom_range(span)), 8'(base + $urandom_range(span)));
            else
                send_random_pixel(OP_MAP);
    endtask

    // Map and finalize straight after reset, on empty histograms.
    task automatic test_after_reset();
        send_beat(OP_MAP, 8'd0, 8'd128, 8'd255);
        send_beat(OP_FINALIZE, 8'd0, 8'd0, 8'd0);
        send_beat(OP_MAP, 8'd255, 8'd1, 8'd0);
    endtask

    // Field extremes, degenerate channels, values below cdfmin, repeated finalize.
    task automatic test_directed_cases();
        send_beat(OP_CLEAR, 8'd0, 8'd0, 8'd0);
        send_beat(OP_ACCUM, 8'd0, 8'd77, 8'd255);
        send_beat(OP_ACCUM, 8'd255, 8'd77, 8'd255);
        send_beat(OP_ACCUM, 8'd10, 8'd77, 8'd0);
        send_beat(OP_ACCUM, 8'd10, 8'd77, 8'd128);
        send_beat(OP_MAP, 8'd10, 8'd77, 8'd255);
        send_beat(OP_FINALIZE, 8'd255, 8'd255, 8'd255);
        send_beat(OP_MAP, 8'd0, 8'd77, 8'd255);
        send_beat(OP_MAP, 8'd10, 8'd5, 8'd128);
        send_beat(OP_MAP, 8'd255, 8'd255, 8'd0);
        // Repeated finalize drives the running sums into saturation.
        repeat (5)
            send_beat(OP_FINALIZE, 8'd0, 8'd0, 8'd0);
        send_beat(OP_MAP, 8'd0, 8'd77, 8'd1);
        send_beat(OP_MAP, 8'd255, 8'd200, 8'd255);
        send_beat(OP_ACCUM, 8'd3, 8'd3, 8'd3);
        send_beat(OP_MAP, 8'd3, 8'd3, 8'd3);
        send_beat(OP_CLEAR, 8'd255, 8'd255, 8'd255);
        send_beat(OP_MAP, 8'd200, 8'd100, 8'd0);
    endtask

    // Frames under several output scales, extremes included.
    task automatic test_scale_settings();
        logic [7:0] scales [5];
        scales = '{8'd1, 8'd255, 8'd128, 8'd2, 8'd0};
        scales[4] = 8'($urandom_range(3, 254));
        foreach (scales[i])
        begin
            write_max_level(scales[i]);
            run_frame($urandom_range(4, 30), $urandom_range(5, 20), $urandom_range(255));
        end
        write_max_level(8'd255);
    endtask

    // Sender never idles for a stretch.
    task automatic test_no_idle();
        idle_pct = 0;
        run_frame(40, 40, 255);
        run_frame(20, 30, 8);
        idle_pct = 15;
    endtask

    // Receiver holds off while beats keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_request = 400;
        repeat (12)
            send_random_pixel(OP_MAP);
        send_random_pixel(OP_FINALIZE);
        repeat (6)
            send_random_pixel(OP_MAP);
    endtask

    // Sender pauses until every result is back, then continues.
    task automatic test_sender_pause();
        run_frame(10, 10, 60);
        drain_results();
        repeat (10)
            send_random_pixel(OP_MAP);
    endtask

    // Mostly well-formed frames with random content, plus noise beats.
    task automatic test_random_frames();
        int sent;
        sent = 0;
        while (sent < 1180)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat (8)
                    send_random_pixel(op_t'($urandom_range(3)));
                sent += 8;
            end
            else
            begin
                int n_acc;
                int n_map;
                n_acc = $urandom_range(1, 40);
                n_map = $urandom_range(1, 25);
                if ($urandom_range(7) == 0)
                    write_max_level(8'($urandom_range(1, 255)));
                run_frame(n_acc, n_map, ($urandom_range(1)) ? 255 : $urandom_range(16));
                sent += n_acc + n_map + 2;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        idle_pct = 15;
        hold_request = 0;
        hold_left = 0;
        scale_level = MAX_LEVEL_RESET;
        clear_histograms();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_directed_cases();
        test_scale_settings();
        test_no_idle();
        test_backpressure();
        test_sender_pause();
        test_random_frames();

        drain_results();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("rgb_histogram_equalizer_unit test passed");
        else
            $display("rgb_histogram_equalizer_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
